FILE: design/asch_pkg.sv
// Shared types, codes and constants for the aging process scheduler.
package asch_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int AGE_BITS_DEF = 16;
  localparam int PID_W        = 16;
  localparam int CFG_W        = 16;
  localparam int SLOT_OUT_W   = 4;
  localparam int SLOT0_AGE    = 50;
  localparam logic [CFG_W-1:0] FORK_AGE_RST = 16'd100;

  typedef logic [1:0] status_t;
  localparam status_t ST_TERM = 2'd0;
  localparam status_t ST_RDY  = 2'd1;
  localparam status_t ST_EXEC = 2'd2;

  typedef logic [1:0] func_t;
  localparam func_t FN_TICK = 2'd0;
  localparam func_t FN_FORK = 2'd1;
  localparam func_t FN_EXIT = 2'd2;
  localparam func_t FN_KILL = 2'd3;

  // per-field write enables of the slot table
  typedef struct packed {
    logic st;
    logic age;
    logic id;
  } wen_t;

  // per-entry verdicts from the shared slot unit
  typedef struct packed {
    logic live;
    logic older;
    logic hit;
  } alu_flags_t;

endpackage

FILE: design/asch_store.sv
// Slot table: status, age and id memories, one write and one registered read a cycle.
module asch_store #(
  parameter int SLOTS    = asch_pkg::SLOTS_DEF,
  parameter int AGE_BITS = asch_pkg::AGE_BITS_DEF,
  localparam int IW      = $clog2(SLOTS)
) (
  input  logic                       clk,
  input  logic [IW-1:0]              raddr,
  output asch_pkg::status_t          rd_st,
  output logic [AGE_BITS-1:0]        rd_age,
  output logic [asch_pkg::PID_W-1:0] rd_id,
  input  asch_pkg::wen_t             we,
  input  logic [IW-1:0]              waddr,
  input  asch_pkg::status_t          wst,
  input  logic [AGE_BITS-1:0]        wage,
  input  logic [asch_pkg::PID_W-1:0] wid
);

  asch_pkg::status_t          st_mem  [SLOTS];
  logic [AGE_BITS-1:0]        age_mem [SLOTS];
  logic [asch_pkg::PID_W-1:0] id_mem  [SLOTS];

  always_ff @(posedge clk) begin
    if (we.st) begin
      st_mem[waddr] <= wst;
    end
    if (we.age) begin
      age_mem[waddr] <= wage;
    end
    if (we.id) begin
      id_mem[waddr] <= wid;
    end
    rd_st  <= st_mem[raddr];
    rd_age <= age_mem[raddr];
    rd_id  <= id_mem[raddr];
  end

endmodule

FILE: design/asch_alu.sv
// Shared per-slot unit: age step (zero for executing or terminated slots, else saturating), age compare and id match.
module asch_alu #(
  parameter int AGE_BITS = asch_pkg::AGE_BITS_DEF
) (
  input  asch_pkg::status_t          st,
  input  logic [AGE_BITS-1:0]        age,
  input  logic [asch_pkg::PID_W-1:0] id,
  input  logic [AGE_BITS-1:0]        fav_age,
  input  logic [asch_pkg::PID_W-1:0] target,
  output logic [AGE_BITS-1:0]        aged,
  output asch_pkg::alu_flags_t       flags
);

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  always_comb begin
    if (st == asch_pkg::ST_EXEC || st == asch_pkg::ST_TERM) begin
      aged = '0;
    end else if (age == AGE_MAX) begin
      aged = age;
    end else begin
      aged = age + AGE_BITS'(1);
    end
    flags.live  = (st != asch_pkg::ST_TERM);
    flags.older = (age > fav_age);
    flags.hit   = (id == target);
  end

endmodule

FILE: design/aging_process_scheduler.sv
// Aging process scheduler top level: sequencer over the slot table and slot unit.
// The core takes one event word at a time: a new word is accepted only in the idle state,
//   once the result of the last one has been loaded into the output register.
// Slot scans go through the table one slot per cycle, set by its single read port.
// Reset (rst_n low, synchronous): control state to its initial values, then the init
//   state writes slot 0 (executing, age 50) before the first word is taken.
module aging_process_scheduler #(
  parameter int SLOTS    = asch_pkg::SLOTS_DEF,
  parameter int AGE_BITS = asch_pkg::AGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // event channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [asch_pkg::PID_W-1:0]      in_target_pid,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [asch_pkg::SLOT_OUT_W-1:0] out_running_slot,
  output logic [asch_pkg::SLOT_OUT_W-1:0] out_child_slot,
  output logic [asch_pkg::PID_W-1:0]      out_child_pid,
  output logic                            out_table_full,
  // fork_initial_age register
  input  logic                            cfg_wr_en,
  input  logic [asch_pkg::CFG_W-1:0]      cfg_wr_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int OW = asch_pkg::SLOT_OUT_W;
  localparam int PW = asch_pkg::PID_W;
  localparam logic [CW-1:0]       SLOTS_C = CW'(SLOTS);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_TICK, S_SCHED, S_FAVRD, S_FAVCAP, S_SCAN,
    S_RUNRD, S_RUNWR, S_FAVWR, S_EXIT, S_FORK, S_FORKWR, S_KILL, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // architectural state
  logic [CW-1:0]           n_r, n_nxt;          // slots in use
  logic [IW-1:0]           run_r, run_nxt;      // running index
  logic [IW-1:0]           fav_r, fav_nxt;      // favoured index
  logic                    phase_r, phase_nxt;  // console phase
  logic [PW-1:0]           last_id_r, last_id_nxt;
  logic [asch_pkg::CFG_W-1:0] cfg_age_r, cfg_age_nxt;

  // working registers of one event
  logic [PW-1:0]           tgt_r, tgt_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;      // scan issue pointer
  logic                    rv_r, rv_nxt;        // read data valid for ridx_r
  logic [IW-1:0]           ridx_r, ridx_nxt;
  logic [AGE_BITS-1:0]     fav_age_r, fav_age_nxt;
  logic                    found_r, found_nxt;
  logic [IW-1:0]           child_r, child_nxt;
  logic [PW-1:0]           cpid_r, cpid_nxt;
  logic                    full_r, full_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic [OW-1:0]           out_run_r, out_run_nxt;
  logic [OW-1:0]           out_child_r, out_child_nxt;
  logic [PW-1:0]           out_cpid_r, out_cpid_nxt;
  logic                    out_full_r, out_full_nxt;

  // table port
  logic [IW-1:0]           raddr;
  asch_pkg::status_t       rd_st;
  logic [AGE_BITS-1:0]     rd_age;
  logic [PW-1:0]           rd_id;
  asch_pkg::wen_t          we;
  logic [IW-1:0]           waddr;
  asch_pkg::status_t       wst;
  logic [AGE_BITS-1:0]     wage;
  logic [PW-1:0]           wid;

  logic [AGE_BITS-1:0]     aged;
  asch_pkg::alu_flags_t    flags;

  logic                    issuing;
  logic                    scan_st;
  logic [AGE_BITS+15:0]    fage_ext;
  logic [AGE_BITS-1:0]     fork_age;
  logic [IW+OW-1:0]        run_ext;
  logic [IW+OW-1:0]        child_ext;

  asch_store #(.SLOTS(SLOTS), .AGE_BITS(AGE_BITS)) u_store (
    .clk    (clk),
    .raddr  (raddr),
    .rd_st  (rd_st),
    .rd_age (rd_age),
    .rd_id  (rd_id),
    .we     (we),
    .waddr  (waddr),
    .wst    (wst),
    .wage   (wage),
    .wid    (wid)
  );

  asch_alu #(.AGE_BITS(AGE_BITS)) u_alu (
    .st      (rd_st),
    .age     (rd_age),
    .id      (rd_id),
    .fav_age (fav_age_r),
    .target  (tgt_r),
    .aged    (aged),
    .flags   (flags)
  );

  // fork age saturates to the age width
  assign fage_ext = {{AGE_BITS{1'b0}}, cfg_age_r};
  assign fork_age = (fage_ext > {16'd0, AGE_MAX}) ? AGE_MAX : fage_ext[AGE_BITS-1:0];

  // slot numbers leave through a 4-bit field
  assign run_ext   = {{OW{1'b0}}, run_r};
  assign child_ext = {{OW{1'b0}}, child_r};

  assign issuing = (cnt_r < n_r);
  assign scan_st = (state_r == S_TICK) || (state_r == S_SCAN) ||
                   (state_r == S_FORK) || (state_r == S_KILL);

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_running_slot = out_run_r;
  assign out_child_slot   = out_child_r;
  assign out_child_pid    = out_cpid_r;
  assign out_table_full   = out_full_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    run_nxt       = run_r;
    fav_nxt       = fav_r;
    phase_nxt     = phase_r;
    last_id_nxt   = last_id_r;
    cfg_age_nxt   = cfg_wr_en ? cfg_wr_data : cfg_age_r;
    tgt_nxt       = tgt_r;
    cnt_nxt       = cnt_r;
    rv_nxt        = 1'b0;
    ridx_nxt      = cnt_r[IW-1:0];
    fav_age_nxt   = fav_age_r;
    found_nxt     = found_r;
    child_nxt     = child_r;
    cpid_nxt      = cpid_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_run_nxt   = out_run_r;
    out_child_nxt = out_child_r;
    out_cpid_nxt  = out_cpid_r;
    out_full_nxt  = out_full_r;

    raddr = cnt_r[IW-1:0];
    we    = '0;
    waddr = ridx_r;
    wst   = asch_pkg::ST_TERM;
    wage  = '0;
    wid   = '0;

    // scan pipeline: issue one slot read a cycle, handle it the next cycle
    if (scan_st && issuing) begin
      rv_nxt  = 1'b1;
      cnt_nxt = cnt_r + CW'(1);
    end

    unique case (state_r)
      S_INIT: begin
        we        = '{st: 1'b1, age: 1'b1, id: 1'b1};
        waddr     = '0;
        wst       = asch_pkg::ST_EXEC;
        wage      = AGE_BITS'(asch_pkg::SLOT0_AGE);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt   = in_target_pid;
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          child_nxt = '0;
          cpid_nxt  = '0;
          full_nxt  = 1'b0;
          unique case (in_func)
            asch_pkg::FN_TICK: state_nxt = S_TICK;
            asch_pkg::FN_FORK: state_nxt = S_FORK;
            asch_pkg::FN_EXIT: state_nxt = S_EXIT;
            asch_pkg::FN_KILL: state_nxt = S_KILL;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        if (rv_r) begin
          we.age = 1'b1;
          wage   = aged;
        end
        if (!issuing && !rv_r) begin
          state_nxt = S_SCHED;
        end
      end
      S_EXIT: begin
        we.st     = 1'b1;
        waddr     = run_r;
        wst       = asch_pkg::ST_TERM;
        state_nxt = S_SCHED;
      end
      S_SCHED: begin
        phase_nxt = ~phase_r;
        if (!phase_r) begin
          fav_nxt   = '0;
          state_nxt = S_RUNRD;
        end else begin
          state_nxt = S_FAVRD;
        end
      end
      S_FAVRD: begin
        raddr     = fav_r;
        state_nxt = S_FAVCAP;
      end
      S_FAVCAP: begin
        fav_age_nxt = rd_age;
        cnt_nxt     = CW'(1);
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        // strictly older live slot takes over; ties keep the current favourite
        if (rv_r && flags.live && flags.older) begin
          fav_nxt     = ridx_r;
          fav_age_nxt = rd_age;
        end
        if (!issuing && !rv_r) begin
          state_nxt = S_RUNRD;
        end
      end
      S_RUNRD: begin
        raddr     = run_r;
        state_nxt = S_RUNWR;
      end
      S_RUNWR: begin
        if (flags.live) begin
          we.st = 1'b1;
          waddr = run_r;
          wst   = asch_pkg::ST_RDY;
        end
        state_nxt = S_FAVWR;
      end
      S_FAVWR: begin
        we.st     = 1'b1;
        waddr     = fav_r;
        wst       = asch_pkg::ST_EXEC;
        run_nxt   = fav_r;
        state_nxt = S_DONE;
      end
      S_FORK: begin
        if (rv_r && !flags.live && !found_r) begin
          found_nxt = 1'b1;
          child_nxt = ridx_r;
        end
        if (!issuing && !rv_r) begin
          state_nxt = S_FORKWR;
        end
      end
      S_FORKWR: begin
        if (found_r || (n_r < SLOTS_C)) begin
          we          = '{st: 1'b1, age: 1'b1, id: 1'b1};
          waddr       = found_r ? child_r : n_r[IW-1:0];
          wst         = asch_pkg::ST_RDY;
          wage        = fork_age;
          wid         = last_id_r + PW'(1);
          last_id_nxt = last_id_r + PW'(1);
          cpid_nxt    = last_id_r + PW'(1);
          if (!found_r) begin
            child_nxt = n_r[IW-1:0];
            n_nxt     = n_r + CW'(1);
          end
        end else begin
          full_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_KILL: begin
        if (rv_r && flags.hit) begin
          we.st = 1'b1;
          wst   = asch_pkg::ST_TERM;
        end
        if (!issuing && !rv_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // output register frees the core once the previous word is taken
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_run_nxt   = run_ext[OW-1:0];
          out_child_nxt = child_ext[OW-1:0];
          out_cpid_nxt  = cpid_r;
          out_full_nxt  = full_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      n_r         <= CW'(1);
      run_r       <= '0;
      fav_r       <= '0;
      phase_r     <= 1'b0;
      last_id_r   <= '0;
      cfg_age_r   <= asch_pkg::FORK_AGE_RST;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      run_r       <= run_nxt;
      fav_r       <= fav_nxt;
      phase_r     <= phase_nxt;
      last_id_r   <= last_id_nxt;
      cfg_age_r   <= cfg_age_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r       <= tgt_nxt;
    ridx_r      <= ridx_nxt;
    fav_age_r   <= fav_age_nxt;
    found_r     <= found_nxt;
    child_r     <= child_nxt;
    cpid_r      <= cpid_nxt;
    full_r      <= full_nxt;
    out_run_r   <= out_run_nxt;
    out_child_r <= out_child_nxt;
    out_cpid_r  <= out_cpid_nxt;
    out_full_r  <= out_full_nxt;
  end

`ifndef SYNTHESIS
  // slots in use stays within the table
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r >= CW'(1)) && (n_r <= SLOTS_C))
    else $error("slots in use out of range");

  // running and favoured slots always lie inside the used part of the table
  a_run_used: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(run_r) < n_r) && (CW'(fav_r) < n_r))
    else $error("running or favoured slot beyond slots in use");

  // a full table word never carries a child
  a_full_no_child: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> (out_cpid_r == '0) && (out_child_r == '0))
    else $error("table full reported with a child");

  // read data only pending while a scan runs
  a_rv_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r |-> scan_st)
    else $error("slot read pending outside a scan");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the aging process scheduler: event words in, one result word out.
module testbench;

  localparam int NSLOTS  = asch_pkg::SLOTS_DEF;
  localparam int AGE_W   = asch_pkg::AGE_BITS_DEF;
  localparam int PID_W   = asch_pkg::PID_W;
  localparam int CFG_W   = asch_pkg::CFG_W;
  localparam int SOUT_W  = asch_pkg::SLOT_OUT_W;
  localparam logic [AGE_W-1:0] AGE_SAT = '1;

  // receiver stall patterns
  localparam int RX_ALWAYS = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_MOSTLY = 3;

  // one result word, field order as on the result port
  typedef struct packed {
    logic [SOUT_W-1:0] running_slot;
    logic [SOUT_W-1:0] child_slot;
    logic [PID_W-1:0]  child_pid;
    logic              table_full;
  } sched_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_func;
  logic [PID_W-1:0]  in_target_pid;
  logic              out_valid;
  logic              out_ready;
  logic [SOUT_W-1:0] out_running_slot;
  logic [SOUT_W-1:0] out_child_slot;
  logic [PID_W-1:0]  out_child_pid;
  logic              out_table_full;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_wr_data;

  aging_process_scheduler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_target_pid    (in_target_pid),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_running_slot (out_running_slot),
    .out_child_slot   (out_child_slot),
    .out_child_pid    (out_child_pid),
    .out_table_full   (out_table_full),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Scheduler shadow: our own copy of the slot table and control state. It is
  // advanced once per accepted event word, in acceptance order.
  // ---------------------------------------------------------------------------
  asch_pkg::status_t shadow_status [NSLOTS];
  logic [AGE_W-1:0]  shadow_age    [NSLOTS];
  logic [PID_W-1:0]  shadow_pid    [NSLOTS];
  int                shadow_used;
  int                shadow_running;
  int                shadow_favoured;
  logic              shadow_phase;
  logic [PID_W-1:0]  shadow_last_pid;
  logic [CFG_W-1:0]  shadow_fork_age;

  sched_result_t    pending_results [$];   // predicted words not yet seen on the output
  int               results_checked;
  int               events_sent;
  int               fail_count;

  // sender state
  int               burst_left;
  bit               offering;
  // receiver state; a test asks for a long hold-off through rx_hold_request
  int               rx_hold_request;
  int               rx_hold_left;
  int               rx_mode;
  int               rx_mode_left;

  // Scheduler pass, shared by tick and exit. Phase 1 forces slot 0; phase 0 hunts
  // for a strictly older live slot, comparing against the previous pick.
  function automatic void shadow_reschedule();
    int i;
    shadow_phase = ~shadow_phase;
    if (!shadow_phase) begin
      for (i = 1; i < shadow_used; i++)
        if (shadow_status[i] != asch_pkg::ST_TERM &&
            shadow_age[i] > shadow_age[shadow_favoured])
          shadow_favoured = i;
    end else begin
      shadow_favoured = 0;
    end
    if (shadow_status[shadow_running] != asch_pkg::ST_TERM)
      shadow_status[shadow_running] = asch_pkg::ST_RDY;
    // favoured slot runs even if it was terminated
    shadow_status[shadow_favoured] = asch_pkg::ST_EXEC;
    shadow_running = shadow_favoured;
  endfunction

  function automatic sched_result_t predict_event(asch_pkg::func_t fn,
                                                  logic [PID_W-1:0] target);
    sched_result_t r;
    int            i;
    int            child;
    r = '0;
    child = -1;
    case (fn)
      asch_pkg::FN_TICK: begin
        // only slots in use are touched
        for (i = 0; i < shadow_used; i++) begin
          if (shadow_status[i] == asch_pkg::ST_EXEC || shadow_status[i] == asch_pkg::ST_TERM)
            shadow_age[i] = '0;
          else if (shadow_age[i] != AGE_SAT)
            shadow_age[i] = shadow_age[i] + 1'b1;
        end
        shadow_reschedule();
      end
      asch_pkg::FN_FORK: begin
        // first terminated slot wins, else append, else the table is full
        for (i = 0; i < shadow_used && child < 0; i++)
          if (shadow_status[i] == asch_pkg::ST_TERM)
            child = i;
        if (child < 0 && shadow_used < NSLOTS) begin
          child = shadow_used;
          shadow_used++;
        end
        if (child >= 0) begin
          shadow_last_pid      = shadow_last_pid + 1'b1;
          shadow_pid[child]    = shadow_last_pid;
          shadow_status[child] = asch_pkg::ST_RDY;
          shadow_age[child]    = shadow_fork_age;
          r.child_slot         = child[SOUT_W-1:0];
          r.child_pid          = shadow_last_pid;
        end else begin
          r.table_full = 1'b1;
        end
      end
      asch_pkg::FN_EXIT: begin
        shadow_status[shadow_running] = asch_pkg::ST_TERM;
        shadow_reschedule();
      end
      default: begin
        // kill: the running slot may die here but stays running until the next pass
        for (i = 0; i < shadow_used; i++)
          if (shadow_pid[i] == target)
            shadow_status[i] = asch_pkg::ST_TERM;
      end
    endcase
    r.running_slot = shadow_running[SOUT_W-1:0];
    return r;
  endfunction

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= 10)
      $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // far beyond the slowest legal run (~1900 words)
  initial begin
    #20_000_000;
    $display("FAIL aging_process_scheduler");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction and checking in one process, so that a word accepted on the input
  // and a result taken on the output at the same edge are handled in that order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    sched_result_t want;
    sched_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_results.push_back(predict_event(asch_pkg::func_t'(in_func), in_target_pid));
      if (out_valid && out_ready) begin
        got.running_slot = out_running_slot;
        got.child_slot   = out_child_slot;
        got.child_pid    = out_child_pid;
        got.table_full   = out_table_full;
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected word: run=%0d child=%0d pid=%0d full=%0d",
                                   got.running_slot, got.child_slot, got.child_pid,
                                   got.table_full));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got.running_slot !== want.running_slot || got.child_slot !== want.child_slot ||
              got.child_pid !== want.child_pid || got.table_full !== want.table_full)
            report_failure($sformatf(
              "word %0d mismatch: exp run=%0d child=%0d pid=%0d full=%0d, got %0d/%0d/%0d/%0d",
              results_checked, want.running_slot, want.child_slot, want.child_pid,
              want.table_full, got.running_slot, got.child_slot, got.child_pid,
              got.table_full));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, picked anew whenever its countdown runs out,
  // with an optional long hold-off counted down here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold_left    = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(RX_ALWAYS, RX_MOSTLY);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ready <= (rx_mode_left % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Words go out in bursts; between bursts valid drops for a random gap.
  // Valid stays up across back-to-back words, so it is only ever assigned once
  // per edge. Callers must end a sequence with sender_idle().
  // ---------------------------------------------------------------------------
  task automatic send_event(input asch_pkg::func_t fn, input logic [PID_W-1:0] target);
    if (burst_left == 0) begin
      if (offering)
        in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_target_pid <= target;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    events_sent++;
  endtask

  task automatic sender_idle();
    if (offering)
      in_valid <= 1'b0;
    offering = 1'b0;
  endtask

  // Sender pauses until every predicted word has been checked.
  task automatic wait_for_results();
    sender_idle();
    while (results_checked != events_sent) @(posedge clk);
  endtask

  // Only called with the block idle, from a clock edge.
  task automatic write_fork_age(input logic [CFG_W-1:0] age);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= age;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_fork_age = age;
  endtask

  // Random event mix; kills mostly name a slot that is in use so that they bite.
  task automatic run_random_events(input int count, input int tick_w, input int fork_w,
                                   input int exit_w, input int kill_w);
    int               pick;
    asch_pkg::func_t  fn;
    logic [PID_W-1:0] target;
    repeat (count) begin
      pick = $urandom_range(0, tick_w + fork_w + exit_w + kill_w - 1);
      if (pick < tick_w)
        fn = asch_pkg::FN_TICK;
      else if (pick < tick_w + fork_w)
        fn = asch_pkg::FN_FORK;
      else if (pick < tick_w + fork_w + exit_w)
        fn = asch_pkg::FN_EXIT;
      else
        fn = asch_pkg::FN_KILL;
      target = PID_W'($urandom);
      if (fn == asch_pkg::FN_KILL && $urandom_range(0, 3) != 0)
        target = shadow_pid[$urandom_range(0, shadow_used - 1)];
      send_event(fn, target);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // From reset with the default fork age: fork, both scheduler phases, kill of
  // the running slot, reuse of a terminated slot, exit, and slot 0 forced back.
  task automatic test_startup();
    send_event(asch_pkg::FN_FORK, 16'h0000);   // appends slot 1, age 100
    send_event(asch_pkg::FN_TICK, 16'h0000);   // phase 1: slot 0 forced
    send_event(asch_pkg::FN_TICK, 16'hFFFF);   // phase 0: slot 1 is older
    send_event(asch_pkg::FN_KILL, 16'h0001);   // kills the running slot, which stays running
    send_event(asch_pkg::FN_TICK, 16'h0000);   // terminated slot aged to 0, slot 0 forced
    send_event(asch_pkg::FN_FORK, 16'h0000);   // reuses slot 1
    send_event(asch_pkg::FN_EXIT, 16'h0000);   // slot 0 ends, oldest pick
    send_event(asch_pkg::FN_TICK, 16'h0000);   // slot 0 runs again although terminated
    wait_for_results();
  endtask

  // Fill the table at the largest fork age, overflow it, then let the ages saturate.
  task automatic test_table_full();
    write_fork_age(16'hFFFF);
    repeat (15) send_event(asch_pkg::FN_FORK, PID_W'($urandom));   // last one finds no room
    send_event(asch_pkg::FN_TICK, 16'h0000);   // forked slots stay at the ceiling
    send_event(asch_pkg::FN_KILL, 16'hFFFF);   // no slot carries this id
    send_event(asch_pkg::FN_KILL, 16'h0000);   // slot 0 still has id 0
    wait_for_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering words,
  // so the block backs up and drops in_ready.
  task automatic test_backpressure();
    rx_hold_request = 300;
    run_random_events(30, 3, 3, 2, 2);
    wait_for_results();
  endtask

  // Random phases, each with its own fork age: zero, ceiling, small values that
  // give ties in the oldest pick, and anything.
  task automatic test_random_mix();
    write_fork_age(16'h0000);
    run_random_events(450, 4, 3, 2, 2);
    wait_for_results();
    write_fork_age(16'hFFFF);
    run_random_events(450, 5, 3, 1, 2);
    wait_for_results();
    write_fork_age(CFG_W'($urandom_range(0, 7)));
    run_random_events(450, 4, 2, 2, 3);
    wait_for_results();
    test_backpressure();
    write_fork_age(CFG_W'($urandom));
    run_random_events(500, 3, 3, 2, 2);
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = asch_pkg::FN_TICK;
    in_target_pid   = '0;
    out_ready       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    results_checked = 0;
    events_sent     = 0;
    fail_count      = 0;
    burst_left      = 0;
    offering        = 1'b0;
    rx_hold_request = 0;
    rx_hold_left    = 0;
    rx_mode         = RX_ALWAYS;
    rx_mode_left    = 0;

    // shadow state after reset: slot 0 executing at age 50, the rest terminated
    for (int i = 0; i < NSLOTS; i++) begin
      shadow_status[i] = asch_pkg::ST_TERM;
      shadow_age[i]    = '0;
      shadow_pid[i]    = '0;
    end
    shadow_status[0] = asch_pkg::ST_EXEC;
    shadow_age[0]    = AGE_W'(asch_pkg::SLOT0_AGE);
    shadow_used      = 1;
    shadow_running   = 0;
    shadow_favoured  = 0;
    shadow_phase     = 1'b0;
    shadow_last_pid  = '0;
    shadow_fork_age  = asch_pkg::FORK_AGE_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_startup();
    test_table_full();
    test_random_mix();

    // let any stray word show up before the verdict
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS aging_process_scheduler");
    end else begin
      $display("FAIL aging_process_scheduler");
    end
    $finish;
  end

endmodule

FILE: aging_process_scheduler.f
design/asch_pkg.sv
design/asch_store.sv
design/asch_alu.sv
design/aging_process_scheduler.sv
dv/testbench.sv
